// ===== design/rgb_curve_saturation_transform_core_defines.svh =====
// assertion macros used by the checker file
`ifndef RGB_CURVE_SATURATION_TRANSFORM_CORE_DEFINES_SVH
`define RGB_CURVE_SATURATION_TRANSFORM_CORE_DEFINES_SVH

// condition in this cycle implies property in the same cycle
`define RCST_ASSERT_IMPLY(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error(msg);

// condition in this cycle implies property in the next cycle
`define RCST_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error(msg);

// property holds in every cycle out of reset
`define RCST_ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

`endif

// ===== design/rcst_pkg.sv =====
`timescale 1ns / 1ps
package rcst_pkg;

	localparam int LEVELS_DEFAULT = 256;
	localparam int NUM_CH         = 3;
	localparam int CMD_W          = 1;
	localparam int LEVEL_W        = 8;
	localparam int CHAN_W         = 2;
	localparam int ENTRY_W        = 17;
	localparam int SAT_W          = 15;
	localparam int COEF_W         = 17;
	localparam int PROD_W         = 35;
	localparam int ACC_W          = 37;
	localparam int OUT_W          = 20;
	localparam int FRAC_SHIFT     = 14;
	localparam int PIPE_DEPTH     = 4;

	localparam logic [CMD_W-1:0] CMD_PIXEL = 1'b0;
	localparam logic [CMD_W-1:0] CMD_CURVE = 1'b1;

	localparam logic [SAT_W-1:0] SAT_RESET = 15'd16056;
	localparam logic signed [16:0] SAT_ONE   = 17'sd16384;
	localparam logic signed [14:0] THIRD_Q14 = 15'sd5461;
	localparam logic [ENTRY_W-1:0] ENTRY_MAX = {ENTRY_W{1'b1}};

	localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1 << (FRAC_SHIFT - 1));
	localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W - 1){1'b1}}};
	localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W - 1){1'b0}}};

	typedef logic [ENTRY_W-1:0] entry_t;
	typedef logic signed [COEF_W-1:0] coef_val_t;

	typedef struct packed {
		coef_val_t off;
		coef_val_t diag;
	} coef_t;

	typedef struct packed {
		logic   valid;
		entry_t red;
		entry_t green;
		entry_t blue;
	} curve_stage_t;

endpackage

// ===== design/rcst_ifs.sv =====
`timescale 1ns / 1ps
interface rcst_pix_if;
	import rcst_pkg::*;

	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   command;
	logic [LEVEL_W-1:0] red;
	logic [LEVEL_W-1:0] green;
	logic [LEVEL_W-1:0] blue;
	logic [CHAN_W-1:0]  curve_channel;
	logic [LEVEL_W-1:0] curve_index;
	entry_t             curve_value;

	modport source (
		output valid, command, red, green, blue, curve_channel, curve_index, curve_value,
		input  ready
	);
	modport sink (
		input  valid, command, red, green, blue, curve_channel, curve_index, curve_value,
		output ready
	);
endinterface

interface rcst_res_if;
	import rcst_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] out_red;
	logic signed [OUT_W-1:0] out_green;
	logic signed [OUT_W-1:0] out_blue;

	modport source (output valid, out_red, out_green, out_blue, input ready);
	modport sink (input valid, out_red, out_green, out_blue, output ready);
endinterface

interface rcst_cfg_if;
	import rcst_pkg::*;

	logic             valid;
	logic             ready;
	logic [SAT_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ===== design/rcst_coef.sv =====
`timescale 1ns / 1ps
module rcst_coef (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	input  logic [rcst_pkg::SAT_W-1:0] cfg_data,
	output rcst_pkg::coef_t           coef
);
	import rcst_pkg::*;

	logic [SAT_W-1:0]   sat_q;
	logic signed [16:0] span;
	logic signed [31:0] off_prod;
	logic signed [31:0] sat_scaled;
	logic signed [31:0] off_round;
	logic signed [31:0] diag_round;
	logic signed [31:0] off_shf;
	logic signed [31:0] diag_shf;
	coef_val_t          off_q;
	coef_val_t          diag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q <= SAT_RESET;
		end else if (cfg_valid) begin
			sat_q <= cfg_data;
		end
	end

	// off = round((1 - s) * third), diag folds s in exactly before rounding
	assign span       = SAT_ONE - $signed({2'b00, sat_q});
	assign off_prod   = span * THIRD_Q14;
	assign sat_scaled = $signed({3'b000, sat_q, 14'b0});
	assign off_round  = off_prod + 32'sd8192;
	assign diag_round = off_prod + sat_scaled + 32'sd8192;
	assign off_shf    = off_round >>> FRAC_SHIFT;
	assign diag_shf   = diag_round >>> FRAC_SHIFT;

	always_ff @(posedge clk) begin
		off_q  <= $signed(off_shf[COEF_W-1:0]);
		diag_q <= $signed(diag_shf[COEF_W-1:0]);
	end

	assign coef.off  = off_q;
	assign coef.diag = diag_q;

endmodule

// ===== design/rcst_curve_mem.sv =====
`timescale 1ns / 1ps
module rcst_curve_mem #(
	parameter int CHANNEL_LEVELS = rcst_pkg::LEVELS_DEFAULT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         pix_valid,
	output logic                         pix_ready,
	input  logic [rcst_pkg::CMD_W-1:0]   command,
	input  logic [rcst_pkg::LEVEL_W-1:0] red,
	input  logic [rcst_pkg::LEVEL_W-1:0] green,
	input  logic [rcst_pkg::LEVEL_W-1:0] blue,
	input  logic [rcst_pkg::CHAN_W-1:0]  curve_channel,
	input  logic [rcst_pkg::LEVEL_W-1:0] curve_index,
	input  rcst_pkg::entry_t             curve_value,
	input  logic                         s2_ready,
	output rcst_pkg::curve_stage_t       s1
);
	import rcst_pkg::*;

	localparam int ADDR_W = (CHANNEL_LEVELS > 1) ? $clog2(CHANNEL_LEVELS) : 1;
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CHANNEL_LEVELS - 1);

	function automatic logic [ADDR_W-1:0] clamp_level(input logic [LEVEL_W-1:0] lvl);
		logic [31:0] wide;
		wide = 32'(lvl);
		if (wide >= 32'(CHANNEL_LEVELS)) begin
			return LAST_ADDR;
		end
		return wide[ADDR_W-1:0];
	endfunction

	// default curve: level i maps to i + 1, saturated to the entry range
	function automatic entry_t reset_entry(input logic [ADDR_W-1:0] addr);
		logic [31:0] v;
		v = (32'(addr) + 32'd1) << 8;
		if (v > 32'(ENTRY_MAX)) begin
			return ENTRY_MAX;
		end
		return v[ENTRY_W-1:0];
	endfunction

	entry_t            curve_q [NUM_CH][CHANNEL_LEVELS];
	entry_t            rd_s1 [NUM_CH];
	logic              v_s1;
	logic              clearing_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic              en1;
	logic              accept;
	logic [ADDR_W-1:0] rd_addr [NUM_CH];
	logic [ADDR_W-1:0] wr_addr;
	entry_t            wr_data;
	logic              wr_en [NUM_CH];

	assign en1       = !v_s1 || s2_ready;
	assign pix_ready = en1 && !clearing_q;
	assign accept    = pix_valid && pix_ready;

	assign rd_addr[0] = clamp_level(red);
	assign rd_addr[1] = clamp_level(green);
	assign rd_addr[2] = clamp_level(blue);

	assign wr_addr = clearing_q ? clr_addr_q : clamp_level(curve_index);
	assign wr_data = clearing_q ? reset_entry(clr_addr_q) : curve_value;

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			wr_en[c] = clearing_q ||
				(accept && command == CMD_CURVE && curve_channel == CHAN_W'(c));
		end
	end

	// clearing pass loads the default curve after reset, one level a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			if (clr_addr_q == LAST_ADDR) begin
				clearing_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= accept && command == CMD_PIXEL;
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < NUM_CH; c++) begin
			if (wr_en[c]) begin
				curve_q[c][wr_addr] <= wr_data;
			end
			if (en1) begin
				rd_s1[c] <= curve_q[c][rd_addr[c]];
			end
		end
	end

	assign s1.valid = v_s1;
	assign s1.red   = rd_s1[0];
	assign s1.green = rd_s1[1];
	assign s1.blue  = rd_s1[2];

endmodule

// ===== design/rcst_mix.sv =====
`timescale 1ns / 1ps
module rcst_mix (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rcst_pkg::curve_stage_t              s1,
	input  rcst_pkg::coef_t                     coef,
	output logic                                s2_ready,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [rcst_pkg::OUT_W-1:0]   out_red,
	output logic signed [rcst_pkg::OUT_W-1:0]   out_green,
	output logic signed [rcst_pkg::OUT_W-1:0]   out_blue
);
	import rcst_pkg::*;

	entry_t                   tone [NUM_CH];
	logic signed [PROD_W-1:0] prod [NUM_CH][NUM_CH];
	logic signed [PROD_W-1:0] prod_s2 [NUM_CH][NUM_CH];
	logic signed [ACC_W-1:0]  acc_s3 [NUM_CH];
	logic signed [ACC_W-1:0]  shf [NUM_CH];
	logic signed [OUT_W-1:0]  sat [NUM_CH];
	logic signed [OUT_W-1:0]  res_s4 [NUM_CH];
	logic                     v_s2;
	logic                     v_s3;
	logic                     v_s4;
	logic                     en2;
	logic                     en3;
	logic                     en4;

	assign en4      = !v_s4 || out_ready;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign s2_ready = en2;

	assign tone[0] = s1.red;
	assign tone[1] = s1.green;
	assign tone[2] = s1.blue;

	// output k takes the diagonal coefficient on its own channel
	always_comb begin
		for (int k = 0; k < NUM_CH; k++) begin
			for (int j = 0; j < NUM_CH; j++) begin
				prod[k][j] = $signed({1'b0, tone[j]}) * ((j == k) ? coef.diag : coef.off);
			end
		end
	end

	// rounded sum shifted back to 8 fraction bits, then clipped to the field
	always_comb begin
		for (int k = 0; k < NUM_CH; k++) begin
			shf[k] = acc_s3[k] >>> FRAC_SHIFT;
			if (shf[k] > ACC_W'(OUT_MAX)) begin
				sat[k] = OUT_MAX;
			end else if (shf[k] < ACC_W'(OUT_MIN)) begin
				sat[k] = OUT_MIN;
			end else begin
				sat[k] = $signed(shf[k][OUT_W-1:0]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en2) begin
				v_s2 <= s1.valid;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
			if (en4) begin
				v_s4 <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < NUM_CH; k++) begin
			if (en2) begin
				for (int j = 0; j < NUM_CH; j++) begin
					prod_s2[k][j] <= prod[k][j];
				end
			end
			if (en3) begin
				acc_s3[k] <= ACC_W'(prod_s2[k][0]) + ACC_W'(prod_s2[k][1]) +
					ACC_W'(prod_s2[k][2]) + ROUND_BIAS;
			end
			if (en4) begin
				res_s4[k] <= sat[k];
			end
		end
	end

	assign out_valid = v_s4;
	assign out_red   = res_s4[0];
	assign out_green = res_s4[1];
	assign out_blue  = res_s4[2];

endmodule

// ===== design/rgb_curve_saturation_transform_core.sv =====
`timescale 1ns / 1ps
// channel  modport  handshake      payload
// pix      sink     valid / ready  command, red, green, blue,
//                                  curve_channel, curve_index, curve_value
// cfg      sink     valid / ready  data (saturation, Q1.14)
// res      source   valid / ready  out_red, out_green, out_blue
//
// one item per clock sustained while res.ready holds high; a taken pixel reaches res
// through curve memory read, nine-multiplier stage, sum stage and clip stage
// a curve write updates the memory when taken and yields no result
// after reset a clearing pass over all CHANNEL_LEVELS levels loads the default
// curve with pix.ready low; cfg.ready is always high
// each stage advances when the next is empty or moving, so bubbles collapse
module rgb_curve_saturation_transform_core #(
	parameter int CHANNEL_LEVELS = rcst_pkg::LEVELS_DEFAULT
) (
	input logic        clk,
	input logic        arst_n,
	rcst_pix_if.sink   pix,
	rcst_cfg_if.sink   cfg,
	rcst_res_if.source res
);
	import rcst_pkg::*;

	coef_t        coef;
	curve_stage_t s1;
	logic         s2_ready;

	assign cfg.ready = 1'b1;

	rcst_coef u_coef (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg.valid),
		.cfg_data  (cfg.data),
		.coef      (coef)
	);

	rcst_curve_mem #(
		.CHANNEL_LEVELS (CHANNEL_LEVELS)
	) u_curve_mem (
		.clk           (clk),
		.arst_n        (arst_n),
		.pix_valid     (pix.valid),
		.pix_ready     (pix.ready),
		.command       (pix.command),
		.red           (pix.red),
		.green         (pix.green),
		.blue          (pix.blue),
		.curve_channel (pix.curve_channel),
		.curve_index   (pix.curve_index),
		.curve_value   (pix.curve_value),
		.s2_ready      (s2_ready),
		.s1            (s1)
	);

	rcst_mix u_mix (
		.clk       (clk),
		.arst_n    (arst_n),
		.s1        (s1),
		.coef      (coef),
		.s2_ready  (s2_ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.out_red   (res.out_red),
		.out_green (res.out_green),
		.out_blue  (res.out_blue)
	);

endmodule

// ===== design/rcst_checker.sv =====
`timescale 1ns / 1ps
`include "rgb_curve_saturation_transform_core_defines.svh"
module rcst_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              pix_valid,
	input logic                              pix_ready,
	input logic [rcst_pkg::CMD_W-1:0]        pix_command,
	input logic                              res_valid,
	input logic                              res_ready,
	input logic signed [rcst_pkg::OUT_W-1:0] res_red,
	input logic signed [rcst_pkg::OUT_W-1:0] res_green,
	input logic signed [rcst_pkg::OUT_W-1:0] res_blue
);
	import rcst_pkg::*;

	logic [2:0] pending_q;
	logic       pix_in;
	logic       res_out;

	assign pix_in  = pix_valid && pix_ready && pix_command == CMD_PIXEL;
	assign res_out = res_valid && res_ready;

	// pixel items taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 3'(pix_in) - 3'(res_out);
		end
	end

	`RCST_ASSERT_IMPLY(a_no_invented_result, clk, arst_n, res_valid, pending_q != '0, "result with no pending pixel")
	`RCST_ASSERT_ALWAYS(a_pending_bound, clk, arst_n, pending_q <= PIPE_DEPTH, "more pixels in flight than stages")
	`RCST_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res_red) && $stable(res_green) && $stable(res_blue), "stalled result changed")

endmodule

bind rgb_curve_saturation_transform_core rcst_checker u_rcst_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.pix_valid   (pix.valid),
	.pix_ready   (pix.ready),
	.pix_command (pix.command),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.res_red     (res.out_red),
	.res_green   (res.out_green),
	.res_blue    (res.out_blue)
);

// ===== tb/tb_rgb_curve_saturation_transform_core.sv =====
`timescale 1ns / 1ps
module tb_rgb_curve_saturation_transform_core;
	import rcst_pkg::*;

	localparam int LEVELS = LEVELS_DEFAULT;
	localparam int QUIET_LIMIT = 2000;
	localparam int SETTLE_CYCLES = PIPE_DEPTH + 4;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int MAX_PRINTED = 100;

	localparam logic [CHAN_W-1:0] CURVE_CH_RED    = 2'd0;
	localparam logic [CHAN_W-1:0] CURVE_CH_GREEN  = 2'd1;
	localparam logic [CHAN_W-1:0] CURVE_CH_BLUE   = 2'd2;
	localparam logic [CHAN_W-1:0] CURVE_CH_UNUSED = 2'd3;

	typedef struct {
		logic [CMD_W-1:0]   command;
		logic [LEVEL_W-1:0] red;
		logic [LEVEL_W-1:0] green;
		logic [LEVEL_W-1:0] blue;
		logic [CHAN_W-1:0]  curve_channel;
		logic [LEVEL_W-1:0] curve_index;
		entry_t             curve_value;
	} pix_item_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] red;
		logic signed [OUT_W-1:0] green;
		logic signed [OUT_W-1:0] blue;
	} rgb_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rcst_pix_if pix_bus ();
	rcst_cfg_if cfg_bus ();
	rcst_res_if res_bus ();

	rgb_curve_saturation_transform_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix_bus),
		.cfg    (cfg_bus),
		.res    (res_bus)
	);

	entry_t           tone_lut [NUM_CH][LEVELS];
	logic [SAT_W-1:0] sat_model;
	rgb_result_t      expected_pixels [$];
	rgb_result_t      want;
	int               error_count = 0;
	int               quiet_cycles = 0;
	bit               src_fast = 1'b0;
	bit               sink_fast = 1'b0;
	int               sink_hold_cycles = 0;

	always #5 clk = ~clk;

	task automatic report_mismatch(input string what);
		error_count++;
		if (error_count <= MAX_PRINTED)
			$display("[%0t] mismatch: %s", $time, what);
	endtask

	function automatic int level_slot(input logic [LEVEL_W-1:0] lvl);
		return (int'(lvl) >= LEVELS) ? LEVELS - 1 : int'(lvl);
	endfunction

	// curve lookup, then saturation matrix, rounded to q8 and clipped
	function automatic rgb_result_t mix_pixel(input logic [LEVEL_W-1:0] r, g, b);
		longint                  curve_val [NUM_CH];
		longint                  off_c;
		longint                  diag_c;
		longint                  acc;
		longint                  rounded;
		logic signed [OUT_W-1:0] mixed [NUM_CH];
		rgb_result_t             res_v;
		curve_val[0] = longint'(tone_lut[0][level_slot(r)]);
		curve_val[1] = longint'(tone_lut[1][level_slot(g)]);
		curve_val[2] = longint'(tone_lut[2][level_slot(b)]);
		off_c = ((longint'(SAT_ONE) - longint'(sat_model)) * longint'(THIRD_Q14)
			+ (longint'(1) << (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
		diag_c = off_c + longint'(sat_model);
		for (int k = 0; k < NUM_CH; k++) begin
			acc = 0;
			for (int j = 0; j < NUM_CH; j++)
				acc += curve_val[j] * ((j == k) ? diag_c : off_c);
			rounded = (acc + (longint'(1) << (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
			if (rounded > longint'(OUT_MAX))
				rounded = longint'(OUT_MAX);
			if (rounded < longint'(OUT_MIN))
				rounded = longint'(OUT_MIN);
			mixed[k] = OUT_W'(rounded);
		end
		res_v.red = mixed[0];
		res_v.green = mixed[1];
		res_v.blue = mixed[2];
		return res_v;
	endfunction

	// prediction and checking share one block so push always precedes pop
	always @(posedge clk) begin
		if (arst_n) begin
			if (pix_bus.valid && pix_bus.ready) begin
				if (pix_bus.command == CMD_CURVE) begin
					if (int'(pix_bus.curve_channel) < NUM_CH)
						tone_lut[pix_bus.curve_channel][level_slot(pix_bus.curve_index)] =
							pix_bus.curve_value;
				end else begin
					expected_pixels.push_back(mix_pixel(pix_bus.red, pix_bus.green,
						pix_bus.blue));
				end
			end
			if (cfg_bus.valid && cfg_bus.ready)
				sat_model = cfg_bus.data;
			if (res_bus.valid && res_bus.ready) begin
				if (expected_pixels.size() == 0) begin
					report_mismatch($sformatf("unexpected result %0d %0d %0d",
						res_bus.out_red, res_bus.out_green, res_bus.out_blue));
				end else begin
					want = expected_pixels.pop_front();
					if (res_bus.out_red !== want.red)
						report_mismatch($sformatf("out_red got %0d want %0d",
							res_bus.out_red, $signed(want.red)));
					if (res_bus.out_green !== want.green)
						report_mismatch($sformatf("out_green got %0d want %0d",
							res_bus.out_green, $signed(want.green)));
					if (res_bus.out_blue !== want.blue)
						report_mismatch($sformatf("out_blue got %0d want %0d",
							res_bus.out_blue, $signed(want.blue)));
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((pix_bus.valid && pix_bus.ready) || (res_bus.valid && res_bus.ready)
			|| (cfg_bus.valid && cfg_bus.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[%0t] timeout: no item moved for %0d cycles, %0d results pending",
				$time, quiet_cycles, expected_pixels.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// result side: random stall per item, or a long hold-off on request
	initial begin : result_sink
		int stall;
		res_bus.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = sink_fast ? 0 : $urandom_range(0, 16);
			if (sink_hold_cycles > 0) begin
				stall = sink_hold_cycles;
				sink_hold_cycles = 0;
			end
			if (stall > 0) begin
				res_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_bus.ready <= 1'b1;
			@(posedge clk);
			while (!res_bus.valid) @(posedge clk);
		end
	end

	function automatic pix_item_t random_item();
		pix_item_t it;
		it.command = ($urandom_range(0, 9) < 3) ? CMD_CURVE : CMD_PIXEL;
		it.red = LEVEL_W'($urandom_range(0, 255));
		it.green = LEVEL_W'($urandom_range(0, 255));
		it.blue = LEVEL_W'($urandom_range(0, 255));
		it.curve_channel = CHAN_W'($urandom_range(0, 3));
		it.curve_index = LEVEL_W'($urandom_range(0, 255));
		it.curve_value = ENTRY_W'($urandom_range(0, 131071));
		return it;
	endfunction

	// fields that a command ignores stay random
	function automatic pix_item_t pixel_item(input logic [LEVEL_W-1:0] r, g, b);
		pix_item_t it;
		it = random_item();
		it.command = CMD_PIXEL;
		it.red = r;
		it.green = g;
		it.blue = b;
		return it;
	endfunction

	function automatic pix_item_t curve_item(input logic [CHAN_W-1:0] ch,
		input logic [LEVEL_W-1:0] idx, input entry_t value);
		pix_item_t it;
		it = random_item();
		it.command = CMD_CURVE;
		it.curve_channel = ch;
		it.curve_index = idx;
		it.curve_value = value;
		return it;
	endfunction

	// valid stays high into the next item when there is no gap
	task automatic send_item(input pix_item_t it);
		int gap;
		gap = src_fast ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			pix_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_bus.valid <= 1'b1;
		pix_bus.command <= it.command;
		pix_bus.red <= it.red;
		pix_bus.green <= it.green;
		pix_bus.blue <= it.blue;
		pix_bus.curve_channel <= it.curve_channel;
		pix_bus.curve_index <= it.curve_index;
		pix_bus.curve_value <= it.curve_value;
		@(posedge clk);
		while (!pix_bus.ready) @(posedge clk);
	endtask

	// curve writes give no result, so let the pipe settle after the last one
	task automatic drain_results();
		pix_bus.valid <= 1'b0;
		// first let the last accepted item reach the queue
		@(posedge clk);
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_saturation(input logic [SAT_W-1:0] value);
		drain_results();
		cfg_bus.data <= value;
		cfg_bus.valid <= 1'b1;
		@(posedge clk);
		while (!cfg_bus.ready) @(posedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic test_default_curve();
		send_item(pixel_item(8'd0, 8'd0, 8'd0));
		send_item(pixel_item(8'd255, 8'd255, 8'd255));
		send_item(pixel_item(8'd255, 8'd0, 8'd0));
		send_item(pixel_item(8'd0, 8'd255, 8'd0));
		send_item(pixel_item(8'd0, 8'd0, 8'd255));
		send_item(pixel_item(8'd128, 8'd64, 8'd200));
		drain_results();
	endtask

	task automatic test_curve_writes();
		send_item(curve_item(CURVE_CH_RED, 8'd255, ENTRY_MAX));
		send_item(curve_item(CURVE_CH_GREEN, 8'd0, '0));
		send_item(curve_item(CURVE_CH_BLUE, 8'd128, ENTRY_MAX));
		// channel 3 write must leave every table alone
		send_item(curve_item(CURVE_CH_UNUSED, 8'd0, '0));
		send_item(pixel_item(8'd255, 8'd0, 8'd128));
		send_item(pixel_item(8'd0, 8'd255, 8'd0));
		// pixel right behind a write to the entry it reads
		src_fast = 1'b1;
		send_item(curve_item(CURVE_CH_GREEN, 8'd17, 17'h1abcd));
		send_item(pixel_item(8'd17, 8'd17, 8'd17));
		send_item(curve_item(CURVE_CH_RED, 8'd17, 17'd1));
		send_item(pixel_item(8'd17, 8'd17, 8'd17));
		src_fast = 1'b0;
		drain_results();
	endtask

	task automatic test_saturation_extremes();
		set_saturation('0);
		send_item(pixel_item(8'd255, 8'd0, 8'd128));
		send_item(pixel_item(8'd10, 8'd200, 8'd30));
		set_saturation({SAT_W{1'b1}});
		send_item(pixel_item(8'd255, 8'd0, 8'd128));
		send_item(pixel_item(8'd10, 8'd200, 8'd30));
		set_saturation(SAT_W'(SAT_ONE));
		send_item(pixel_item(8'd255, 8'd0, 8'd128));
		set_saturation(SAT_RESET);
	endtask

	task automatic test_output_backpressure();
		src_fast = 1'b1;
		sink_fast = 1'b1;
		sink_hold_cycles = HOLD_OFF_CYCLES;
		repeat (60) send_item(random_item());
		drain_results();
		src_fast = 1'b0;
		sink_fast = 1'b0;
	endtask

	task automatic test_random_traffic();
		for (int phase = 0; phase < 4; phase++) begin
			set_saturation(SAT_W'($urandom_range(0, 32767)));
			src_fast = (phase == 1) || (phase == 2);
			sink_fast = (phase == 1) || (phase == 3);
			repeat (240) send_item(random_item());
		end
		drain_results();
		src_fast = 1'b0;
		sink_fast = 1'b0;
	endtask

	initial begin : stimulus
		pix_bus.valid <= 1'b0;
		pix_bus.command <= CMD_PIXEL;
		pix_bus.red <= '0;
		pix_bus.green <= '0;
		pix_bus.blue <= '0;
		pix_bus.curve_channel <= CURVE_CH_RED;
		pix_bus.curve_index <= '0;
		pix_bus.curve_value <= '0;
		cfg_bus.valid <= 1'b0;
		cfg_bus.data <= '0;
		for (int c = 0; c < NUM_CH; c++)
			for (int i = 0; i < LEVELS; i++)
				tone_lut[c][i] = ((i + 1) << 8) > int'(ENTRY_MAX) ? ENTRY_MAX
					: ENTRY_W'((i + 1) << 8);
		sat_model = SAT_RESET;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		test_default_curve();
		test_curve_writes();
		test_saturation_extremes();
		test_output_backpressure();
		test_random_traffic();

		drain_results();
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== rgb_curve_saturation_transform_core.f =====
+incdir+design
design/rcst_pkg.sv
design/rcst_ifs.sv
design/rcst_coef.sv
design/rcst_curve_mem.sv
design/rcst_mix.sv
design/rgb_curve_saturation_transform_core.sv
design/rcst_checker.sv
tb/tb_rgb_curve_saturation_transform_core.sv
